// ===== design/mclw_pkg.sv =====
`default_nettype none

package mclw_pkg;

    localparam int MAX_CHANNELS_DEF = 8;
    localparam int RESULT_LIMIT     = 8;
    localparam int TIME_W           = 32;
    localparam int CH_ID_W          = 3;
    localparam int CNT_W            = 4;
    localparam int CFG_IDX_W        = 2;
    localparam int CFG_DATA_W       = 32;

    localparam logic       CMD_TICK = 1'b0;
    localparam logic       CMD_DONE = 1'b1;

    localparam logic [CFG_IDX_W-1:0] REG_DEADLINE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CHANNELS = 2'd1;

    localparam logic [TIME_W-1:0] DEADLINE_RST = 32'd1000;
    localparam logic [CNT_W-1:0]  CHANNELS_RST = 4'd8;

    typedef struct packed {
        logic              cmd;
        logic [CH_ID_W-1:0] channel;
        logic [TIME_W-1:0] time_now;
    } in_t;

    typedef struct packed {
        logic [CH_ID_W-1:0] channel_id;
        logic               lag_valid;
        logic [TIME_W-1:0]  lag;
        logic               exceeded_event;
        logic               probe_posted;
        logic               channel_healthy;
        logic               fleet_healthy;
        logic               last;
    } out_t;

    // Visit token walking along the row of cells during a tick.
    typedef struct packed {
        logic              active;
        logic              all_ok;
        logic [TIME_W-1:0] now;
    } tok_t;

    // Completion stamp delivered to one cell.
    typedef struct packed {
        logic              we;
        logic [TIME_W-1:0] stamp;
    } upd_t;

endpackage

`default_nettype wire

// ===== design/multi_channel_liveness_watchdog.sv =====
// Channel  Ports                               Direction  Carries
// input    s_valid, s_ready, s_data            in         tick or probe completion
// result   m_valid, m_ready, m_data            out        one report per visited channel
// config   cfg_valid, cfg_ready, cfg_index,    in         deadline, channels in use
//          cfg_data
//
// A completion updates its channel cell and yields no result. A tick sends a token along
// the row of channel cells, one cell per cycle unless the result register stalls; the
// next item is taken once the token has left the last visited cell. A stalled result
// register holds the token where it stands. Reset is synchronous and active low; all
// channels come out healthy and never posted.
`default_nettype none

module multi_channel_liveness_watchdog import mclw_pkg::*; #(
    parameter int MAX_CHANNELS = MAX_CHANNELS_DEF
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  s_valid,
    output logic                       s_ready,
    input  wire in_t                   s_data,
    output logic                       m_valid,
    input  wire logic                  m_ready,
    output out_t                       m_data,
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int LIMIT = (MAX_CHANNELS < RESULT_LIMIT) ? MAX_CHANNELS : RESULT_LIMIT;

    logic [TIME_W-1:0] deadline_reg;
    logic [CNT_W-1:0]  channels_reg;
    logic              m_valid_reg;
    out_t              m_data_reg;

    logic [CNT_W-1:0]  cnt;
    logic              adv;
    logic              s_fire;
    logic              any_active;
    tok_t              start_tok;
    out_t              res_or;

    tok_t              tok_in  [MAX_CHANNELS];
    tok_t              tok_out [MAX_CHANNELS];
    upd_t              upd     [MAX_CHANNELS];
    out_t              res     [MAX_CHANNELS];
    logic [MAX_CHANNELS-1:0] act;

    assign cfg_ready  = 1'b1;
    assign any_active = |act;
    assign s_ready    = !any_active;
    assign s_fire     = s_valid && s_ready;
    assign adv        = !m_valid_reg || m_ready;
    assign m_valid    = m_valid_reg;
    assign m_data     = m_data_reg;

    always_comb begin
        if (channels_reg == '0) begin
            cnt = CNT_W'(1);
        end else if (32'(channels_reg) > LIMIT) begin
            cnt = CNT_W'(LIMIT);
        end else begin
            cnt = channels_reg;
        end
    end

    always_comb begin
        start_tok.active = s_fire && (s_data.cmd == CMD_TICK);
        start_tok.all_ok = 1'b1;
        start_tok.now    = s_data.time_now;
    end

    // Only the cell holding the token drives a non-zero result.
    always_comb begin
        res_or = '0;
        for (int i = 0; i < MAX_CHANNELS; i++) begin
            res_or = res_or | res[i];
        end
    end

    for (genvar g = 0; g < MAX_CHANNELS; g++) begin : g_cell
        if (g == 0) begin : g_head
            assign tok_in[g] = start_tok.active ? start_tok : tok_out[MAX_CHANNELS-1];
        end else begin : g_body
            assign tok_in[g] = tok_out[g-1];
        end

        assign upd[g].we    = s_fire && (s_data.cmd == CMD_DONE)
                              && (32'(s_data.channel) == g);
        assign upd[g].stamp = s_data.time_now;

        mclw_cell #(
            .IDX (g)
        ) u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .adv      (adv),
            .is_last  (32'(cnt) == g + 1),
            .deadline (deadline_reg),
            .upd      (upd[g]),
            .tok_in   (tok_in[g]),
            .tok_out  (tok_out[g]),
            .active   (act[g]),
            .res      (res[g])
        );
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            deadline_reg <= DEADLINE_RST;
            channels_reg <= CHANNELS_RST;
            m_valid_reg  <= 1'b0;
        end else begin
            if (cfg_valid) begin
                case (cfg_index)
                    REG_DEADLINE: deadline_reg <= cfg_data;
                    REG_CHANNELS: channels_reg <= cfg_data[CNT_W-1:0];
                    default: ;
                endcase
            end
            if (adv) begin
                m_valid_reg <= any_active;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (adv && any_active) begin
            m_data_reg <= res_or;
        end
    end

endmodule

`default_nettype wire

// ===== design/mclw_cell.sv =====
`default_nettype none

module mclw_cell import mclw_pkg::*; #(
    parameter int IDX = 0
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              adv,
    input  wire logic              is_last,
    input  wire logic [TIME_W-1:0] deadline,
    input  wire upd_t              upd,
    input  wire tok_t              tok_in,
    output tok_t                   tok_out,
    output logic                   active,
    output out_t                   res
);

    tok_t              tok_reg;
    logic [TIME_W-1:0] post_reg;
    logic [TIME_W-1:0] finish_reg;
    logic              done_reg;
    logic              ever_reg;
    logic              exc_reg;
    logic              healthy_reg;

    logic [TIME_W-1:0] base;
    logic [TIME_W-1:0] elapsed;
    logic              late;
    logic              hit;
    logic              lag_valid;
    logic              healthy_next;
    logic              all_next;
    logic              fire;

    assign active  = tok_reg.active;
    assign fire    = tok_reg.active && adv;

    always_comb begin
        base         = done_reg ? finish_reg : tok_reg.now;
        elapsed      = base - post_reg;
        late         = elapsed >= deadline;
        hit          = ever_reg && late && !exc_reg;
        lag_valid    = done_reg && ever_reg;
        healthy_next = hit ? 1'b0 : healthy_reg;
        if (lag_valid && !late) begin
            healthy_next = 1'b1;
        end
        all_next = tok_reg.all_ok && healthy_next;
    end

    always_comb begin
        tok_out        = tok_reg;
        tok_out.active = fire && !is_last;
        tok_out.all_ok = all_next;
    end

    always_comb begin
        res = '0;
        if (tok_reg.active) begin
            res.channel_id      = CH_ID_W'(IDX);
            res.lag_valid       = lag_valid;
            res.lag             = lag_valid ? elapsed : '0;
            res.exceeded_event  = hit;
            res.probe_posted    = done_reg;
            res.channel_healthy = healthy_next;
            res.fleet_healthy   = is_last && all_next;
            res.last            = is_last;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tok_reg     <= '0;
            post_reg    <= '0;
            finish_reg  <= '0;
            done_reg    <= 1'b1;
            ever_reg    <= 1'b0;
            exc_reg     <= 1'b0;
            healthy_reg <= 1'b1;
        end else begin
            if (tok_in.active) begin
                tok_reg <= tok_in;
            end else if (fire) begin
                tok_reg.active <= 1'b0;
            end
            if (upd.we) begin
                finish_reg <= upd.stamp;
                done_reg   <= 1'b1;
            end else if (fire) begin
                healthy_reg <= healthy_next;
                if (done_reg) begin
                    post_reg <= tok_reg.now;
                    done_reg <= 1'b0;
                    exc_reg  <= 1'b0;
                    ever_reg <= 1'b1;
                end else begin
                    exc_reg <= exc_reg || hit;
                end
            end
        end
    end

endmodule

`default_nettype wire

// ===== design/mclw_checker.sv =====
`default_nettype none

module mclw_checker import mclw_pkg::*; (
    input wire logic                  aclk,
    input wire logic                  aresetn,
    input wire logic                  m_valid,
    input wire logic                  m_ready,
    input wire out_t                  m_data
);

    // A result waiting on the consumer stays put.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result changed while stalled");

    a_fleet_only_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_data.last |-> !m_data.fleet_healthy)
        else $error("fleet_healthy set before the last result");

    a_lag_reposts: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.lag_valid |-> m_data.probe_posted)
        else $error("lag reported without a new probe");

    a_lag_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_data.lag_valid |-> m_data.lag == '0)
        else $error("lag non-zero without lag_valid");

    // A deadline miss on a probe still outstanding must leave the channel unhealthy.
    a_miss_unhealthy: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.exceeded_event && !m_data.lag_valid |-> !m_data.channel_healthy)
        else $error("missed deadline left channel healthy");

endmodule

bind multi_channel_liveness_watchdog mclw_checker u_mclw_checker (.*);

`default_nettype wire

// ===== bench/tb.sv =====
`timescale 1ns / 1ps

module tb;
    import mclw_pkg::*;

    localparam int STALL_LIMIT = 4000;
    localparam int SETTLE_CYCLES = 16;

    // Tracks the per-channel probe state and predicts the reports of every tick.
    class health_predictor;
        logic [TIME_W-1:0] deadline;
        logic [CNT_W-1:0]  chan_count;
        logic [TIME_W-1:0] post_at [MAX_CHANNELS_DEF];
        logic [TIME_W-1:0] finish_at [MAX_CHANNELS_DEF];
        bit                probe_back [MAX_CHANNELS_DEF];
        bit                was_posted [MAX_CHANNELS_DEF];
        bit                late_seen [MAX_CHANNELS_DEF];
        bit                healthy [MAX_CHANNELS_DEF];
        out_t              due_reports [$];
        int                errors;

        function new();
            errors = 0;
            deadline = DEADLINE_RST;
            chan_count = CHANNELS_RST;
            for (int c = 0; c < MAX_CHANNELS_DEF; c++) begin
                post_at[c] = '0;
                finish_at[c] = '0;
                probe_back[c] = 1'b1;
                was_posted[c] = 1'b0;
                late_seen[c] = 1'b0;
                healthy[c] = 1'b1;
            end
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
            if (idx == REG_DEADLINE)
                deadline = val;
            else if (idx == REG_CHANNELS)
                chan_count = val[CNT_W-1:0];
        endfunction

        function void take_item(in_t item);
            int                visits;
            logic [TIME_W-1:0] elapsed;
            bit                all_ok;
            out_t              rpt;
            if (item.cmd == CMD_DONE) begin
                finish_at[item.channel] = item.time_now;
                probe_back[item.channel] = 1'b1;
                return;
            end
            // A count of zero still visits one channel; large counts saturate.
            if (chan_count == 0)
                visits = 1;
            else if (chan_count > MAX_CHANNELS_DEF)
                visits = MAX_CHANNELS_DEF;
            else
                visits = int'(chan_count);
            all_ok = 1'b1;
            for (int c = 0; c < visits; c++) begin
                elapsed = (probe_back[c] ? finish_at[c] : item.time_now) - post_at[c];
                rpt = '0;
                rpt.channel_id = CH_ID_W'(c);
                if (was_posted[c] && elapsed >= deadline && !late_seen[c]) begin
                    rpt.exceeded_event = 1'b1;
                    healthy[c] = 1'b0;
                    late_seen[c] = 1'b1;
                end
                if (probe_back[c]) begin
                    if (was_posted[c]) begin
                        rpt.lag_valid = 1'b1;
                        rpt.lag = elapsed;
                        if (elapsed < deadline)
                            healthy[c] = 1'b1;
                    end
                    post_at[c] = item.time_now;
                    probe_back[c] = 1'b0;
                    late_seen[c] = 1'b0;
                    was_posted[c] = 1'b1;
                    rpt.probe_posted = 1'b1;
                end
                if (!healthy[c])
                    all_ok = 1'b0;
                rpt.channel_healthy = healthy[c];
                if (c == visits - 1) begin
                    rpt.fleet_healthy = all_ok;
                    rpt.last = 1'b1;
                end
                due_reports.insert(due_reports.size(), rpt);
            end
        endfunction

        function void match_field(string name, logic [TIME_W-1:0] want,
                                  logic [TIME_W-1:0] got);
            if (want !== got) begin
                $error("%s: expected %0h, got %0h", name, want, got);
                errors++;
            end
        endfunction

        function void match_report(out_t got);
            out_t want;
            if (due_reports.size() == 0) begin
                $error("report on channel %0d with none outstanding", got.channel_id);
                errors++;
                return;
            end
            want = due_reports.pop_front();
            match_field("channel_id", TIME_W'(want.channel_id), TIME_W'(got.channel_id));
            match_field("lag_valid", TIME_W'(want.lag_valid), TIME_W'(got.lag_valid));
            match_field("lag", want.lag, got.lag);
            match_field("exceeded_event", TIME_W'(want.exceeded_event),
                        TIME_W'(got.exceeded_event));
            match_field("probe_posted", TIME_W'(want.probe_posted),
                        TIME_W'(got.probe_posted));
            match_field("channel_healthy", TIME_W'(want.channel_healthy),
                        TIME_W'(got.channel_healthy));
            match_field("fleet_healthy", TIME_W'(want.fleet_healthy),
                        TIME_W'(got.fleet_healthy));
            match_field("last", TIME_W'(want.last), TIME_W'(got.last));
        endfunction
    endclass

    logic                  aclk;
    logic                  aresetn;
    logic                  s_valid;
    logic                  s_ready;
    in_t                   s_data;
    logic                  m_valid;
    logic                  m_ready;
    out_t                  m_data;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    health_predictor   pred;
    bit                steady;
    int                idle_cycles;
    logic [TIME_W-1:0] t_now;

    multi_channel_liveness_watchdog u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Mostly no gap, often a short one, now and then a long one.
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (steady || r < 50)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // All transfers are observed here, in one place, at the rising edge.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready)
                pred.take_item(s_data);
            if (m_valid && m_ready)
                pred.match_report(m_data);
            if (cfg_valid && cfg_ready)
                pred.write_reg(cfg_index, cfg_data);
            if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= STALL_LIMIT) begin
                $display("Regression FAIL");
                $finish;
            end
        end
    end

    initial begin
        int hold;
        hold = 0;
        m_ready = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold > 0) begin
                m_ready = 1'b0;
                hold--;
            end else begin
                m_ready = 1'b1;
                hold = gap_len();
            end
        end
    end

    task automatic send(input logic cmd, input logic [CH_ID_W-1:0] ch,
                        input logic [TIME_W-1:0] tm);
        int gap;
        gap = gap_len();
        @(negedge aclk);
        if (gap > 0) begin
            s_valid = 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_data.cmd = cmd;
        s_data.channel = ch;
        s_data.time_now = tm;
        s_valid = 1'b1;
        do @(posedge aclk); while (!s_ready);
    endtask

    // Waits for every outstanding report; optionally lets the block settle afterwards.
    task automatic drain(input bit settle);
        @(negedge aclk);
        s_valid = 1'b0;
        while (pred.due_reports.size() != 0)
            @(posedge aclk);
        if (settle)
            repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic set_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        @(negedge aclk);
        cfg_index = idx;
        cfg_data = val;
        cfg_valid = 1'b1;
        do @(posedge aclk); while (!cfg_ready);
        @(negedge aclk);
        cfg_valid = 1'b0;
    endtask

    task automatic configure(input logic [TIME_W-1:0] dl, input logic [CNT_W-1:0] cnt);
        drain(1'b1);
        set_reg(REG_DEADLINE, dl);
        set_reg(REG_CHANNELS, CFG_DATA_W'(cnt));
    endtask

    // Time mostly creeps forward so that lags sit around the deadline; rare jumps.
    task automatic random_item(input int step);
        if ($urandom_range(0, 99) < 6)
            t_now = $urandom();
        else
            t_now = t_now + $urandom_range(0, step);
        if ($urandom_range(0, 99) < 40)
            send(CMD_TICK, CH_ID_W'($urandom_range(0, 7)), t_now);
        else
            send(CMD_DONE, CH_ID_W'($urandom_range(0, 7)), t_now);
    endtask

    initial begin
        logic [TIME_W-1:0] dl;
        logic [CNT_W-1:0]  cnt;
        int                step;
        pred = new();
        steady = 1'b0;
        idle_cycles = 0;
        t_now = '0;
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_data = '0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // First probes, an elapsed time just under and a lag exactly at the deadline, and overdue probes.
        send(CMD_TICK, 3'd0, 32'd0);
        send(CMD_TICK, 3'd0, 32'd999);
        send(CMD_DONE, 3'd1, 32'd400);
        send(CMD_DONE, 3'd0, 32'd1000);
        send(CMD_TICK, 3'd5, 32'd1000);
        send(CMD_TICK, 3'd0, 32'd5000);
        // Repeated completions, a completion with nothing outstanding and time wrapping.
        send(CMD_DONE, 3'd7, 32'hFFFF_FFFF);
        send(CMD_DONE, 3'd7, 32'hFFFF_FF00);
        send(CMD_DONE, 3'd2, 32'd6000);
        send(CMD_TICK, 3'd7, 32'hFFFF_FF80);
        send(CMD_DONE, 3'd3, 32'h0000_0010);
        send(CMD_DONE, 3'd3, 32'h0000_0020);
        send(CMD_DONE, 3'd6, 32'h0000_0030);
        send(CMD_TICK, 3'd0, 32'h0000_0040);

        // Zero deadline, with a channel count of zero standing for one channel.
        configure(32'd0, 4'd0);
        send(CMD_TICK, 3'd0, 32'h0000_0050);
        send(CMD_DONE, 3'd0, 32'h0000_0050);
        send(CMD_TICK, 3'd0, 32'h0000_0050);

        // Largest deadline, with a count above the channel total.
        configure(32'hFFFF_FFFF, 4'd15);
        send(CMD_TICK, 3'd0, 32'h0000_0060);
        send(CMD_DONE, 3'd4, 32'h0000_005F);
        send(CMD_TICK, 3'd0, 32'hFFFF_FFF0);

        configure(32'd1, 4'd1);
        send(CMD_TICK, 3'd0, 32'h0000_0100);
        send(CMD_DONE, 3'd0, 32'h0000_0100);
        send(CMD_TICK, 3'd0, 32'h0000_0101);
        t_now = 32'h0000_0200;

        for (int ph = 0; ph < 6; ph++) begin
            case (ph)
                0: begin
                    dl = $urandom_range(200, 2000);
                    cnt = 4'd8;
                end
                1: begin
                    dl = $urandom_range(1, 3000);
                    cnt = CNT_W'($urandom_range(1, 8));
                end
                2: begin
                    dl = $urandom();
                    cnt = CNT_W'($urandom_range(0, 15));
                end
                3: begin
                    dl = $urandom_range(1, 50);
                    cnt = 4'd3;
                end
                4: begin
                    dl = 32'hFFFF_FFFF;
                    cnt = 4'd8;
                end
                default: begin
                    dl = $urandom_range(1, 3000);
                    cnt = CNT_W'($urandom_range(1, 8));
                    t_now = 32'hFFFF_F000;
                end
            endcase
            configure(dl, cnt);
            steady = (ph == 1);
            step = (dl > 4000) ? 32'h00FF_FFFF : (dl / 3 + 1);
            for (int i = 0; i < 42; i++) begin
                if (ph == 3 && i == 20)
                    drain(1'b0);
                random_item(step);
            end
            steady = 1'b0;
        end

        drain(1'b1);
        if (pred.errors == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
